// File: rtl/pefd_pkg.sv
// ----------------------------------------------------------------------------
// pefd_pkg
// Shared types and constants of the pointer event FIFO device: operation and
// register codes, the sequencer state type and the button-word flag bits.
// ----------------------------------------------------------------------------
package pefd_pkg;

    // Operation codes carried on the op port.
    typedef enum logic [1:0] {
        OP_EVENT = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_TICK  = 2'd3
    } op_t;

    // Word register indexes of the bus side.
    localparam logic [2:0] IDX_CTRL    = 3'd0;
    localparam logic [2:0] IDX_WIDTH   = 3'd1;
    localparam logic [2:0] IDX_HEIGHT  = 3'd2;
    localparam logic [2:0] IDX_X       = 3'd3;
    localparam logic [2:0] IDX_Y       = 3'd4;
    localparam logic [2:0] IDX_BUTTONS = 3'd5;

    // Configuration register indexes.
    localparam logic CFG_SCREEN_WIDTH  = 1'b0;
    localparam logic CFG_SCREEN_HEIGHT = 1'b1;

    // Data-available flag of the button word and enable bit of control.
    localparam int unsigned AVAIL_POS  = 31;
    localparam int unsigned ENABLE_POS = 0;

    // Field widths of one queued event.
    localparam int unsigned BTN_W   = 8;
    localparam int unsigned COORD_W = 16;
    localparam int unsigned WORD_W  = 32;

    typedef struct packed {
        logic [BTN_W-1:0]   buttons;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } event_entry_t;

    // Sequencer states, one-hot.
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_POP  = 2'b10
    } state_t;

endpackage

// File: rtl/pointer_event_fifo_device.sv
// ----------------------------------------------------------------------------
// pointer_event_fifo_device
// Register-mapped pointer input device with an event FIFO held in a
// synchronous memory.
//
// Channel   Signals                                     Direction  Transfer
// command   start, busy, op, reg_index, write_data,     in         start & !busy
//           event_buttons, event_x, event_y
// result    done, read_data, irq_raise                  out        done (1 cycle)
// config    cfg_we, cfg_index, cfg_wdata                in         cfg_we
//
// Every command completes in the cycle it is accepted, except a read of the
// button register while the FIFO holds entries, which waits in the pop state
// for the registered read of the event memory. The result shows on done in
// the cycle after the command's last cycle. Reset clears all control state
// at once; event memory needs no clearing. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module pointer_event_fifo_device #(
    parameter int unsigned QUEUE_DEPTH = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  op,
    input  logic [2:0]  reg_index,
    input  logic [31:0] write_data,
    input  logic [7:0]  event_buttons,
    input  logic [15:0] event_x,
    input  logic [15:0] event_y,
    output logic        done,
    output logic [31:0] read_data,
    output logic        irq_raise,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata
);
    import pefd_pkg::*;

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);

    // Event memory, written at the tail and read at the head.
    event_entry_t mem [QUEUE_DEPTH];
    event_entry_t mem_rdata_reg;
    logic         mem_we;
    event_entry_t mem_wdata;

    state_t            state_reg,   state_next;
    logic [PTR_W-1:0]  head_reg,    head_next;
    logic [PTR_W-1:0]  tail_reg,    tail_next;
    logic [CNT_W-1:0]  count_reg,   count_next;
    logic [WORD_W-1:0] ctrl_reg,    ctrl_next;
    logic [WORD_W-1:0] x_reg,       x_next;
    logic [WORD_W-1:0] y_reg,       y_next;
    logic [WORD_W-1:0] btn_reg,     btn_next;
    logic              pending_reg, pending_next;
    logic [15:0]       width_reg;
    logic [15:0]       height_reg;
    logic              done_reg,    done_next;
    logic [WORD_W-1:0] rdata_reg,   rdata_next;
    logic              irq_reg,     irq_next;

    logic accept;
    op_t  cmd_op;

    assign busy   = state_reg[1];
    assign accept = start && !busy;
    assign cmd_op = op_t'(op);

    assign done      = done_reg;
    assign read_data = rdata_reg;
    assign irq_raise = irq_reg;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        next_slot = (p == LAST_SLOT) ? '0 : p + 1'b1;
    endfunction

    // Memory port: write on a queued event, registered read of the head.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[tail_reg] <= mem_wdata;
        end
        mem_rdata_reg <= mem[head_reg];
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= '0;
            height_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SCREEN_WIDTH:  width_reg  <= cfg_wdata;
                CFG_SCREEN_HEIGHT: height_reg <= cfg_wdata;
                default:           width_reg  <= width_reg;
            endcase
        end
    end

    // Command decode and the pop that completes on the memory data.
    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        ctrl_next    = ctrl_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        btn_next     = btn_reg;
        pending_next = pending_reg;
        done_next    = 1'b0;
        rdata_next   = '0;
        irq_next     = 1'b0;
        mem_we       = 1'b0;
        mem_wdata    = '{buttons: event_buttons, x: event_x, y: event_y};

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    done_next = 1'b1;
                    case (cmd_op)
                        OP_EVENT:
                        begin
                            if (ctrl_reg[ENABLE_POS] && count_reg < FULL_CNT)
                            begin
                                mem_we       = 1'b1;
                                tail_next    = next_slot(tail_reg);
                                count_next   = count_reg + 1'b1;
                                pending_next = 1'b1;
                            end
                        end
                        OP_WRITE:
                        begin
                            case (reg_index)
                                IDX_CTRL:
                                begin
                                    ctrl_next    = write_data;
                                    head_next    = '0;
                                    tail_next    = '0;
                                    count_next   = '0;
                                    pending_next = 1'b0;
                                    btn_next     = '0;
                                end
                                IDX_X:       x_next   = write_data;
                                IDX_Y:       y_next   = write_data;
                                IDX_BUTTONS: btn_next = write_data;
                                default:     ;
                            endcase
                        end
                        OP_READ:
                        begin
                            case (reg_index)
                                IDX_CTRL:   rdata_next = ctrl_reg;
                                IDX_WIDTH:  rdata_next = {16'b0, width_reg};
                                IDX_HEIGHT: rdata_next = {16'b0, height_reg};
                                IDX_X:      rdata_next = x_reg;
                                IDX_Y:      rdata_next = y_reg;
                                IDX_BUTTONS:
                                begin
                                    if (count_reg != '0)
                                    begin
                                        // Wait in the pop state for the registered head entry.
                                        done_next  = 1'b0;
                                        state_next = ST_POP;
                                    end
                                    else
                                    begin
                                        btn_next            = btn_reg;
                                        btn_next[AVAIL_POS] = 1'b0;
                                        rdata_next          = btn_next;
                                    end
                                end
                                default:    rdata_next = '0;
                            endcase
                        end
                        OP_TICK:
                        begin
                            irq_next     = pending_reg;
                            pending_next = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_POP:
            begin
                // Load the oldest entry into the pointer registers.
                btn_next            = {24'b0, mem_rdata_reg.buttons};
                btn_next[AVAIL_POS] = 1'b1;
                x_next              = {16'b0, mem_rdata_reg.x};
                y_next              = {16'b0, mem_rdata_reg.y};
                head_next           = next_slot(head_reg);
                count_next          = count_reg - 1'b1;
                irq_next            = (count_reg > CNT_W'(1));
                rdata_next          = btn_next;
                done_next           = 1'b1;
                state_next          = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and register state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            ctrl_reg    <= '0;
            x_reg       <= '0;
            y_reg       <= '0;
            btn_reg     <= '0;
            pending_reg <= 1'b0;
            done_reg    <= 1'b0;
            irq_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            ctrl_reg    <= ctrl_next;
            x_reg       <= x_next;
            y_reg       <= y_next;
            btn_reg     <= btn_next;
            pending_reg <= pending_next;
            done_reg    <= done_next;
            irq_reg     <= irq_next;
        end
    end

    // Result data needs no reset.
    always_ff @(posedge clk)
    begin
        rdata_reg <= rdata_next;
    end

    // The fill count never passes the queue depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("FIFO count above depth");

    // A pop is only started with an entry in the FIFO.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POP) |-> (count_reg != '0))
        else $error("pop with empty FIFO");

    // A pop always produces its result in the next cycle.
    a_pop_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POP) |=> (done_reg && state_reg == ST_IDLE))
        else $error("pop did not complete");

    // Head and tail meet exactly when the FIFO is empty or full.
    a_ptr_meet: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == FULL_CNT) |-> (head_reg == tail_reg))
        else $error("pointers disagree with count");

    // An interrupt only goes out with a result.
    a_irq_done: assert property (@(posedge clk) disable iff (!rst_n)
        irq_reg |-> done_reg)
        else $error("interrupt without result");

endmodule

// File: verif/pefd_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pefd_checker
// Watches the command, result and configuration ports of the pointer event
// FIFO device. Keeps its own copy of the registers and the event FIFO, works
// out the result of every accepted command and compares each result, field
// by field, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module pefd_checker #(
    parameter int unsigned QUEUE_DEPTH = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  op,
    input  logic [2:0]  reg_index,
    input  logic [31:0] write_data,
    input  logic [7:0]  event_buttons,
    input  logic [15:0] event_x,
    input  logic [15:0] event_y,
    input  logic        done,
    input  logic [31:0] read_data,
    input  logic        irq_raise,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,
    output int          fail_count,
    output int          results_awaited,
    output int          results_checked,
    output int          events_dropped_full
);

    import pefd_pkg::*;

    typedef struct {
        logic [31:0] read_data;
        logic        irq;
    } cmd_result_t;

    // Predicted device state.
    event_entry_t queued_events[$];
    cmd_result_t  expected_results[$];
    logic [31:0]  control_word;
    logic [31:0]  x_word;
    logic [31:0]  y_word;
    logic [31:0]  button_word;
    logic         irq_pending;
    logic [15:0]  screen_width;
    logic [15:0]  screen_height;

    // Track configuration writes, check results, then predict new commands.
    always @(posedge clk or negedge rst_n)
    begin : track
        event_entry_t head_entry;
        cmd_result_t  oldest;
        cmd_result_t  want;

        if (!rst_n)
        begin
            queued_events.delete();
            expected_results.delete();
            control_word        = '0;
            x_word              = '0;
            y_word              = '0;
            button_word         = '0;
            irq_pending         = 1'b0;
            screen_width        = '0;
            screen_height       = '0;
            fail_count          = 0;
            results_awaited     = 0;
            results_checked     = 0;
            events_dropped_full = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_SCREEN_WIDTH)
                    screen_width = cfg_wdata;
                else
                    screen_height = cfg_wdata;
            end

            // A result belongs to a command accepted at an earlier edge.
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result transfer with no command outstanding: read_data %h irq %b",
                           read_data, irq_raise);
                    fail_count++;
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    results_checked++;
                    if (read_data !== oldest.read_data)
                    begin
                        $error("read_data: expected %h, actual %h",
                               oldest.read_data, read_data);
                        fail_count++;
                    end
                    if (irq_raise !== oldest.irq)
                    begin
                        $error("irq_raise: expected %b, actual %b", oldest.irq, irq_raise);
                        fail_count++;
                    end
                end
            end

            if (start && !busy)
            begin
                want.read_data = '0;
                want.irq       = 1'b0;
                case (op_t'(op))
                    OP_EVENT:
                    begin
                        // Queued only while enabled and there is room.
                        if (control_word[ENABLE_POS])
                        begin
                            if (queued_events.size() < QUEUE_DEPTH)
                            begin
                                head_entry.buttons = event_buttons;
                                head_entry.x       = event_x;
                                head_entry.y       = event_y;
                                queued_events.push_back(head_entry);
                                irq_pending = 1'b1;
                            end
                            else
                            begin
                                events_dropped_full++;
                            end
                        end
                    end
                    OP_WRITE:
                    begin
                        case (reg_index)
                            IDX_CTRL:
                            begin
                                queued_events.delete();
                                irq_pending  = 1'b0;
                                button_word  = '0;
                                control_word = write_data;
                            end
                            IDX_X:       x_word = write_data;
                            IDX_Y:       y_word = write_data;
                            IDX_BUTTONS: button_word = write_data;
                            default:     ;
                        endcase
                    end
                    OP_READ:
                    begin
                        case (reg_index)
                            IDX_CTRL:   want.read_data = control_word;
                            IDX_WIDTH:  want.read_data = 32'(screen_width);
                            IDX_HEIGHT: want.read_data = 32'(screen_height);
                            IDX_X:      want.read_data = x_word;
                            IDX_Y:      want.read_data = y_word;
                            IDX_BUTTONS:
                            begin
                                // Reading buttons pops the oldest event if any.
                                if (queued_events.size() > 0)
                                begin
                                    head_entry  = queued_events.pop_front();
                                    button_word = 32'(head_entry.buttons);
                                    button_word[AVAIL_POS] = 1'b1;
                                    x_word      = 32'(head_entry.x);
                                    y_word      = 32'(head_entry.y);
                                    want.irq    = (queued_events.size() > 0);
                                end
                                else
                                begin
                                    button_word[AVAIL_POS] = 1'b0;
                                end
                                want.read_data = button_word;
                            end
                            default:    ;
                        endcase
                    end
                    OP_TICK:
                    begin
                        want.irq    = irq_pending;
                        irq_pending = 1'b0;
                    end
                    default: ;
                endcase
                expected_results.push_back(want);
            end
            results_awaited = expected_results.size();
        end
    end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives commands and screen-size settings into the pointer event FIFO
// device: a directed opening, then random phases that fill and drain the
// event FIFO under several settings. A checker beside the device predicts
// and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

    import pefd_pkg::*;

    localparam int unsigned QUEUE_DEPTH   = 10;
    localparam int          CYCLE_LIMIT   = 200000;
    localparam int          PHASE_ITEMS   = 200;

    // Register indexes that map to nothing.
    localparam logic [2:0]  IDX_UNMAPPED_LO = 3'd6;
    localparam logic [2:0]  IDX_UNMAPPED_HI = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  op;
    logic [2:0]  reg_index;
    logic [31:0] write_data;
    logic [7:0]  event_buttons;
    logic [15:0] event_x;
    logic [15:0] event_y;
    logic        done;
    logic [31:0] read_data;
    logic        irq_raise;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_wdata;

    int fail_count;
    int results_awaited;
    int results_checked;
    int events_dropped_full;
    int cycle_count;
    int op_sent[4];

    pointer_event_fifo_device #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .reg_index    (reg_index),
        .write_data   (write_data),
        .event_buttons(event_buttons),
        .event_x      (event_x),
        .event_y      (event_y),
        .done         (done),
        .read_data    (read_data),
        .irq_raise    (irq_raise),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    pefd_checker #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) i_checker (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .busy               (busy),
        .op                 (op),
        .reg_index          (reg_index),
        .write_data         (write_data),
        .event_buttons      (event_buttons),
        .event_x            (event_x),
        .event_y            (event_y),
        .done               (done),
        .read_data          (read_data),
        .irq_raise          (irq_raise),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .fail_count         (fail_count),
        .results_awaited    (results_awaited),
        .results_checked    (results_checked),
        .events_dropped_full(events_dropped_full)
    );

    // 50 MHz clock.
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("pointer_event_fifo_device test failed");
            $finish;
        end
    end

    // Random values at the widths of the command fields.
    function automatic logic [2:0] rand_idx();
        return 3'($urandom);
    endfunction

    function automatic logic [7:0] rand_btn();
        return 8'($urandom);
    endfunction

    function automatic logic [15:0] rand_coord();
        return 16'($urandom);
    endfunction

    // Present one command and hold it until the transfer happens.
    task automatic issue(input op_t c, input logic [2:0] idx, input logic [31:0] wd,
                         input logic [7:0] b, input logic [15:0] px,
                         input logic [15:0] py);
        @(negedge clk);
        start         <= 1'b1;
        op            <= c;
        reg_index     <= idx;
        write_data    <= wd;
        event_buttons <= b;
        event_x       <= px;
        event_y       <= py;
        do
            @(posedge clk);
        while (busy);
        op_sent[c]++;
    endtask

    // Leave the command port idle for a number of cycles.
    task automatic pause(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    // Stop sending and wait until every outstanding result has come back.
    task automatic drain();
        pause(1);
        while (results_awaited != 0)
            @(negedge clk);
        repeat (4)
            @(negedge clk);
    endtask

    // Set both screen-size registers; only called with the device idle.
    task automatic set_screen(input logic [15:0] w, input logic [15:0] h);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SCREEN_WIDTH;
        cfg_wdata <= w;
        @(negedge clk);
        cfg_index <= CFG_SCREEN_HEIGHT;
        cfg_wdata <= h;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // One random command; event_weight steers the FIFO toward full or empty.
    task automatic send_random(input int event_weight);
        int          pick;
        logic [31:0] wd;

        pick = $urandom_range(0, 99);
        wd   = $urandom;
        if (pick < event_weight)
            issue(OP_EVENT, rand_idx(), wd, rand_btn(), rand_coord(), rand_coord());
        else if (pick < event_weight + 4)
        begin
            // Control writes mostly keep the device enabled.
            if ($urandom_range(0, 3) != 0)
                wd[ENABLE_POS] = 1'b1;
            issue(OP_WRITE, IDX_CTRL, wd, rand_btn(), rand_coord(), rand_coord());
        end
        else if (pick < event_weight + 12)
            issue(OP_WRITE, 3'($urandom_range(1, 7)), wd, rand_btn(), rand_coord(),
                  rand_coord());
        else if (pick < event_weight + 34)
            issue(OP_READ, IDX_BUTTONS, wd, rand_btn(), rand_coord(), rand_coord());
        else if (pick < event_weight + 44)
            issue(OP_READ, rand_idx(), wd, rand_btn(), rand_coord(), rand_coord());
        else
            issue(OP_TICK, rand_idx(), wd, rand_btn(), rand_coord(), rand_coord());
    endtask

    // Stimulus and verdict.
    initial
    begin : stimulus
        int  event_weight;
        bit  no_gaps;

        rst_n         = 1'b0;
        start         = 1'b0;
        op            = OP_TICK;
        reg_index     = '0;
        write_data    = '0;
        event_buttons = '0;
        event_x       = '0;
        event_y       = '0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_SCREEN_WIDTH;
        cfg_wdata     = '0;
        foreach (op_sent[i])
            op_sent[i] = 0;

        repeat (6)
            @(negedge clk);
        rst_n = 1'b1;

        set_screen(16'hFFFF, 16'h0000);

        // Directed opening: register reads, disabled and enabled events,
        // ticks, pops until empty, ignored writes and the empty button read.
        issue(OP_READ,  IDX_WIDTH,   $urandom, rand_btn(), rand_coord(), rand_coord());
        issue(OP_READ,  IDX_HEIGHT,  $urandom, rand_btn(), rand_coord(), rand_coord());
        issue(OP_READ,  IDX_BUTTONS, $urandom, rand_btn(), rand_coord(), rand_coord());
        issue(OP_READ,  IDX_UNMAPPED_HI, $urandom, rand_btn(), rand_coord(), rand_coord());
        issue(OP_EVENT, rand_idx(),  $urandom, 8'hFF, 16'hFFFF, 16'hFFFF);
        issue(OP_TICK,  rand_idx(),  $urandom, rand_btn(), rand_coord(), rand_coord());
        issue(OP_WRITE, IDX_CTRL,    32'h0000_0001, rand_btn(), rand_coord(), rand_coord());
        issue(OP_EVENT, rand_idx(),  $urandom, 8'hFF, 16'hFFFF, 16'hFFFF);
        issue(OP_EVENT, rand_idx(),  $urandom, 8'h00, 16'h0000, 16'h0000);
        issue(OP_TICK,  rand_idx(),  $urandom, rand_btn(), rand_coord(), rand_coord());
        issue(OP_TICK,  rand_idx(),  $urandom, rand_btn(), rand_coord(), rand_coord());
        issue(OP_READ,  IDX_BUTTONS, $urandom, rand_btn(), rand_coord(), rand_coord());
        issue(OP_READ,  IDX_X,       $urandom, rand_btn(), rand_coord(), rand_coord());
        issue(OP_READ,  IDX_Y,       $urandom, rand_btn(), rand_coord(), rand_coord());
        issue(OP_READ,  IDX_BUTTONS, $urandom, rand_btn(), rand_coord(), rand_coord());
        issue(OP_READ,  IDX_BUTTONS, $urandom, rand_btn(), rand_coord(), rand_coord());
        issue(OP_WRITE, IDX_WIDTH,   32'hFFFF_FFFF, rand_btn(), rand_coord(), rand_coord());
        issue(OP_WRITE, IDX_HEIGHT,  32'hFFFF_FFFF, rand_btn(), rand_coord(), rand_coord());
        issue(OP_WRITE, IDX_UNMAPPED_LO, 32'hFFFF_FFFF, rand_btn(), rand_coord(),
              rand_coord());
        issue(OP_READ,  IDX_UNMAPPED_LO, $urandom, rand_btn(), rand_coord(), rand_coord());
        issue(OP_WRITE, IDX_X,       32'hFFFF_FFFF, rand_btn(), rand_coord(), rand_coord());
        issue(OP_WRITE, IDX_BUTTONS, 32'h8000_0001, rand_btn(), rand_coord(), rand_coord());
        issue(OP_READ,  IDX_BUTTONS, $urandom, rand_btn(), rand_coord(), rand_coord());
        issue(OP_WRITE, IDX_CTRL,    32'hFFFF_FFFE, rand_btn(), rand_coord(), rand_coord());
        issue(OP_EVENT, rand_idx(),  $urandom, rand_btn(), rand_coord(), rand_coord());

        // Random phases, each under its own screen size.
        for (int phase = 0; phase < 4; phase++)
        begin
            drain();
            case (phase)
                0:       set_screen(16'h0000, 16'hFFFF);
                1:       set_screen(rand_coord(), rand_coord());
                2:       set_screen(16'hFFFF, 16'hFFFF);
                default: set_screen(16'h0000, 16'h0000);
            endcase
            issue(OP_WRITE, IDX_CTRL, $urandom | 32'h1, rand_btn(), rand_coord(),
                  rand_coord());
            event_weight = (phase % 2 == 0) ? 50 : 30;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (phase == 2 && n == PHASE_ITEMS / 2)
                    drain();
                send_random(event_weight);
                no_gaps = (phase == 1 && n < 80);
                if (!no_gaps && $urandom_range(0, 99) < 25)
                    pause($urandom_range(1, 3));
            end
        end

        drain();
        repeat (8)
            @(posedge clk);

        $display("Sent %0d commands: %0d pointer events, %0d bus writes,",
                 op_sent[OP_EVENT] + op_sent[OP_WRITE] + op_sent[OP_READ] + op_sent[OP_TICK],
                 op_sent[OP_EVENT], op_sent[OP_WRITE]);
        $display("%0d bus reads and %0d ticks.", op_sent[OP_READ], op_sent[OP_TICK]);
        $display("Checked %0d results over five screen sizes; %0d events hit a full FIFO.",
                 results_checked, events_dropped_full);
        if (fail_count == 0)
            $display("pointer_event_fifo_device test passed");
        else
            $display("pointer_event_fifo_device test failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/pefd_pkg.sv
rtl/pointer_event_fifo_device.sv
verif/pefd_checker.sv
verif/tb_top.sv
